// ----- hdl/ctmac_pkg.sv -----
`default_nettype none
package ctmac_pkg;
   localparam int LANES_DEF = 4;
   localparam int OPERAND_BITS_DEF = 16;
   localparam int ACC_BITS_DEF = 40;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COL_COUNT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ADD_TO_EXISTING = 2'd2;
   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/ctmac_if.sv -----
`default_nettype none
interface ctmac_req_if #(parameter int OPERAND_BITS = 16);
   logic valid;
   logic ready;
   logic cmd;
   logic [3:0] slot;
   logic last;
   logic signed [OPERAND_BITS-1:0] a0_re, a0_im, a1_re, a1_im;
   logic signed [OPERAND_BITS-1:0] b0_re, b0_im, b1_re, b1_im;
   modport source(output valid, cmd, slot, last, a0_re, a0_im, a1_re, a1_im,
                  b0_re, b0_im, b1_re, b1_im, input ready);
   modport sink(input valid, cmd, slot, last, a0_re, a0_im, a1_re, a1_im,
                b0_re, b0_im, b1_re, b1_im, output ready);
endinterface

interface ctmac_rsp_if #(parameter int ACC_BITS = 40);
   logic valid;
   logic ready;
   logic [1:0] out_lane;
   logic out_row;
   logic out_col;
   logic signed [ACC_BITS-1:0] out_re;
   logic signed [ACC_BITS-1:0] out_im;
   logic last_of_run;
   modport source(output valid, out_lane, out_row, out_col, out_re, out_im,
                  last_of_run, input ready);
   modport sink(input valid, out_lane, out_row, out_col, out_re, out_im,
                last_of_run, output ready);
endinterface

interface ctmac_csr_if;
   logic valid;
   logic ready;
   logic [ctmac_pkg::CSR_IDX_BITS-1:0] index;
   logic [ctmac_pkg::CSR_DATA_BITS-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/complex_tile_multiply_accumulate_top.sv -----
// Complex 2x2 tile multiply-accumulate over LANES lanes.
// req: one beat is a step (cmd 0) for lane slot[1:0] with A rows and B
// columns, or a preload (cmd 1) of entry slot = lane*4+row*2+col that adds
// a0 shifted left by OPERAND_BITS-1 when add_to_existing is set.
// csr: index 0 row_count, 1 col_count, 2 add_to_existing; write only idle.
// rsp: a step with last emits the lane's in-use entries in row-major order,
// last_of_run on the final one, and the lane is cleared.
// Each lane's tile lives in one memory word (four complex entries) with a
// registered read. Pipeline: read, multiply, add/saturate and write back,
// with forwarding of in-flight words to the read stage. While req_ready is
// high, one beat is taken per cycle; a last step issues 1, 2 or 4 result
// beats, so a stream of last steps is paced by the result channel at one
// beat a cycle. Result beats enter the buffer as their step leaves stage 2.
// An eight-deep result buffer takes up stalls of the receiver; req_ready
// drops unless the buffer has room for what is in flight plus the results
// of one more step.
// After reset the memory is swept to zero, one lane word a cycle, through
// all LANES lanes, during which req_ready is low.
`default_nettype none
module complex_tile_multiply_accumulate_top #(
   parameter int LANES = ctmac_pkg::LANES_DEF,
   parameter int OPERAND_BITS = ctmac_pkg::OPERAND_BITS_DEF,
   parameter int ACC_BITS = ctmac_pkg::ACC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   ctmac_req_if.sink req,
   ctmac_rsp_if.source rsp,
   ctmac_csr_if.sink csr
);
   localparam int LB = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int PB = 2 * OPERAND_BITS;
   localparam int W = 4 * ACC_BITS;
   localparam int QD = 8;
   localparam int QB = 3;
   localparam int SH = OPERAND_BITS - 1;

   logic [1:0] row_count_ff;
   logic [1:0] col_count_ff;
   logic add_ff;
   logic clr_active_ff;
   logic [LB:0] clr_idx_ff;

   logic [W-1:0] mem_re [LANES];
   logic [W-1:0] mem_im [LANES];

   // stage 1: read issued
   logic s1_v_ff, s1_pre_ff, s1_last_ff;
   logic [LB-1:0] s1_lane_ff;
   logic [1:0] s1_ent_ff;
   logic signed [OPERAND_BITS-1:0] s1_a_ff [4];
   logic signed [OPERAND_BITS-1:0] s1_b_ff [4];
   // stage 2: products
   logic s2_v_ff, s2_pre_ff, s2_last_ff;
   logic [LB-1:0] s2_lane_ff;
   logic [1:0] s2_ent_ff;
   logic signed [PB:0] s2_re_ff [4];
   logic signed [PB:0] s2_im_ff [4];
   logic [W-1:0] s2_old_re_ff, s2_old_im_ff;
   // stage 3: written word, forwarded
   logic s3_v_ff;
   logic [LB-1:0] s3_lane_ff;
   logic [W-1:0] s3_re_ff, s3_im_ff;

   logic [W-1:0] rd_re_ff, rd_im_ff;

   // result buffer
   logic [1:0] q_lane [QD];
   logic q_row [QD], q_col [QD], q_lst [QD];
   logic [ACC_BITS-1:0] q_re [QD], q_im [QD];
   logic [QB-1:0] q_wp_ff, q_rp_ff;
   logic [QB:0] q_cnt_ff;

   logic two_rows, two_cols;
   logic [2:0] n_out;
   logic req_fire, is_step, lane_ok, do_op;
   logic [LB-1:0] in_lane;
   logic [1:0] in_ent;
   logic [QB:0] pend;

   assign two_rows = row_count_ff[1];
   assign two_cols = col_count_ff[1];
   assign n_out = (two_rows && two_cols) ? 3'd4 : ((two_rows || two_cols) ? 3'd2 : 3'd1);
   // Reserve room in the buffer for every last step in flight.
   assign pend = ((s1_v_ff && s1_last_ff && !s1_pre_ff) ? {1'b0, n_out} : '0)
               + ((s2_v_ff && s2_last_ff && !s2_pre_ff) ? {1'b0, n_out} : '0);
   assign req.ready = !clr_active_ff && (q_cnt_ff + pend + {1'b0, n_out} <= QD[QB:0]);
   assign req_fire = req.valid && req.ready;
   assign is_step = (req.cmd == ctmac_pkg::CMD_STEP);
   assign in_lane = LB'(is_step ? req.slot[1:0] : req.slot[3:2]);
   assign in_ent = req.slot[1:0];
   always_comb begin
      if (is_step) lane_ok = (32'(req.slot[1:0]) < LANES);
      else lane_ok = (32'(req.slot[3:2]) < LANES) && add_ff;
   end
   assign do_op = req_fire && lane_ok;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 2'd2;
         col_count_ff <= 2'd2;
         add_ff <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.index)
            ctmac_pkg::CSR_ROW_COUNT: row_count_ff <= csr.data;
            ctmac_pkg::CSR_COL_COUNT: col_count_ff <= csr.data;
            ctmac_pkg::CSR_ADD_TO_EXISTING: add_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   function automatic logic [ACC_BITS-1:0] sat(input logic signed [ACC_BITS+1:0] v);
      logic signed [ACC_BITS+1:0] hi, lo;
      hi = {3'b000, {(ACC_BITS-1){1'b1}}};
      lo = ~hi;
      if (v > hi) return hi[ACC_BITS-1:0];
      if (v < lo) return lo[ACC_BITS-1:0];
      return v[ACC_BITS-1:0];
   endfunction

   // memory with clearing sweep and stage-2 write-back
   logic mem_we;
   logic [LB-1:0] mem_wa;
   logic [W-1:0] mem_wre, mem_wim, nre, nim;
   logic [3:0] upd;
   always_comb begin
      upd = '0;
      for (int e = 0; e < 4; e++) begin
         if (s2_pre_ff) upd[e] = (s2_ent_ff == 2'(e));
         else upd[e] = (e[1] == 1'b0 || two_rows) && (e[0] == 1'b0 || two_cols);
      end
      for (int e = 0; e < 4; e++) begin
         nre[e*ACC_BITS +: ACC_BITS] = upd[e]
            ? sat($signed({{2{s2_old_re_ff[e*ACC_BITS+ACC_BITS-1]}},
                  s2_old_re_ff[e*ACC_BITS +: ACC_BITS]}) + (ACC_BITS+2)'(s2_re_ff[e]))
            : s2_old_re_ff[e*ACC_BITS +: ACC_BITS];
         nim[e*ACC_BITS +: ACC_BITS] = upd[e]
            ? sat($signed({{2{s2_old_im_ff[e*ACC_BITS+ACC_BITS-1]}},
                  s2_old_im_ff[e*ACC_BITS +: ACC_BITS]}) + (ACC_BITS+2)'(s2_im_ff[e]))
            : s2_old_im_ff[e*ACC_BITS +: ACC_BITS];
      end
      mem_we = clr_active_ff || s2_v_ff;
      mem_wa = clr_active_ff ? clr_idx_ff[LB-1:0] : s2_lane_ff;
      mem_wre = (clr_active_ff || (s2_v_ff && s2_last_ff && !s2_pre_ff)) ? '0 : nre;
      mem_wim = (clr_active_ff || (s2_v_ff && s2_last_ff && !s2_pre_ff)) ? '0 : nim;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_re[mem_wa] <= mem_wre;
         mem_im[mem_wa] <= mem_wim;
      end
      rd_re_ff <= mem_re[in_lane];
      rd_im_ff <= mem_im[in_lane];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_active_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == (LB+1)'(LANES - 1)) clr_active_ff <= 1'b0;
      end
   end

   // Old value seen by stage 2: newest in-flight write to the same lane.
   logic [W-1:0] old_re, old_im;
   always_comb begin
      old_re = rd_re_ff;
      old_im = rd_im_ff;
      if (s3_v_ff && s3_lane_ff == s1_lane_ff) begin
         old_re = s3_re_ff;
         old_im = s3_im_ff;
      end
      if (s2_v_ff && s2_lane_ff == s1_lane_ff) begin
         old_re = mem_wre;
         old_im = mem_wim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= do_op;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
      s1_pre_ff <= !is_step;
      s1_last_ff <= req.last;
      s1_lane_ff <= in_lane;
      s1_ent_ff <= in_ent;
      s1_a_ff[0] <= req.a0_re; s1_a_ff[1] <= req.a0_im;
      s1_a_ff[2] <= req.a1_re; s1_a_ff[3] <= req.a1_im;
      s1_b_ff[0] <= req.b0_re; s1_b_ff[1] <= req.b0_im;
      s1_b_ff[2] <= req.b1_re; s1_b_ff[3] <= req.b1_im;
      s2_pre_ff <= s1_pre_ff;
      s2_last_ff <= s1_last_ff;
      s2_lane_ff <= s1_lane_ff;
      s2_ent_ff <= s1_ent_ff;
      for (int e = 0; e < 4; e++) begin
         if (s1_pre_ff) begin
            s2_re_ff[e] <= (PB+1)'(s1_a_ff[0]) <<< SH;
            s2_im_ff[e] <= (PB+1)'(s1_a_ff[1]) <<< SH;
         end else begin
            s2_re_ff[e] <= (PB+1)'(s1_a_ff[2*(e/2)] * s1_b_ff[2*(e%2)])
                         - (PB+1)'(s1_a_ff[2*(e/2)+1] * s1_b_ff[2*(e%2)+1]);
            s2_im_ff[e] <= (PB+1)'(s1_a_ff[2*(e/2)+1] * s1_b_ff[2*(e%2)])
                         + (PB+1)'(s1_a_ff[2*(e/2)] * s1_b_ff[2*(e%2)+1]);
         end
      end
      s2_old_re_ff <= old_re;
      s2_old_im_ff <= old_im;
      s3_lane_ff <= s2_lane_ff;
      s3_re_ff <= mem_wre;
      s3_im_ff <= mem_wim;
   end

   // result buffer fill
   logic emit;
   logic [2:0] nw;
   assign emit = s2_v_ff && s2_last_ff && !s2_pre_ff;
   assign nw = emit ? n_out : 3'd0;
   logic q_pop;
   assign q_pop = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (emit) begin
         for (int k = 0; k < 4; k++) begin
            if (3'(k) < n_out) begin
               logic [1:0] e;
               e = (two_rows && two_cols) ? 2'(k)
                 : (two_cols ? {1'b0, k[0]} : (two_rows ? {k[0], 1'b0} : 2'd0));
               q_lane[q_wp_ff + QB'(k)] <= 2'(s2_lane_ff);
               q_row[q_wp_ff + QB'(k)] <= e[1];
               q_col[q_wp_ff + QB'(k)] <= e[0];
               q_lst[q_wp_ff + QB'(k)] <= (3'(k) == n_out - 3'd1);
               q_re[q_wp_ff + QB'(k)] <= nre[e*ACC_BITS +: ACC_BITS];
               q_im[q_wp_ff + QB'(k)] <= nim[e*ACC_BITS +: ACC_BITS];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff <= '0;
         q_rp_ff <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wp_ff <= q_wp_ff + QB'(nw);
         if (q_pop) q_rp_ff <= q_rp_ff + 1'b1;
         q_cnt_ff <= q_cnt_ff + (QB+1)'(nw) - (QB+1)'(q_pop);
      end
   end

   assign rsp.valid = (q_cnt_ff != '0);
   assign rsp.out_lane = q_lane[q_rp_ff];
   assign rsp.out_row = q_row[q_rp_ff];
   assign rsp.out_col = q_col[q_rp_ff];
   assign rsp.out_re = q_re[q_rp_ff];
   assign rsp.out_im = q_im[q_rp_ff];
   assign rsp.last_of_run = q_lst[q_rp_ff];

`ifndef SYNTHESIS
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QD[QB:0]) else $error("result buffer overflow");
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req.ready) else $error("input taken during clear");
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |=> s2_v_ff) else $error("pipeline lost a beat");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> q_cnt_ff + {1'b0, n_out} <= QD[QB:0] + (QB+1)'(q_pop))
      else $error("no room for results");
`endif
endmodule
`default_nettype wire
